>>> rtl/etw_pkg.sv
// ----------------------------------------------------------------------------
// etw_pkg
// Shared types and codes for the event threshold window table.
// ----------------------------------------------------------------------------
package etw_pkg;

   localparam int ENTRIES_DEF = 16;

   localparam logic [1:0] OP_PROGRAM = 2'd0;
   localparam logic [1:0] OP_EVENT   = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic [1:0] CAUSE_COUNT_EVENT   = 2'd0;
   localparam logic [1:0] CAUSE_COUNT_TICK    = 2'd1;
   localparam logic [1:0] CAUSE_TIME          = 2'd2;
   localparam logic [1:0] CAUSE_UNTHRESHOLDED = 2'd3;

   // command broadcast from the sequencer to every cell
   typedef struct packed {
      logic        prog;
      logic        evt;
      logic [3:0]  entry;
      logic [15:0] count_add;
      logic [31:0] now_time;
      logic [31:0] count_limit;
      logic [31:0] time_limit;
      logic        enabled;
   } cmd_type;

   // status reported by each cell
   typedef struct packed {
      logic       hit;
      logic [1:0] cause;
      logic       ev_hit;
   } cell_stat_type;

endpackage

>>> rtl/etw_cell.sv
// ----------------------------------------------------------------------------
// etw_cell
// One rule entry: thresholds, window state and the scan token stage.
// ----------------------------------------------------------------------------
module etw_cell #(
   parameter int CELL_ID = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  etw_pkg::cmd_type      cmd,
   input  logic                  advance,
   input  logic                  tok_in,
   output logic                  tok_out,
   output etw_pkg::cell_stat_type stat
);
   import etw_pkg::*;

   logic        open_ff,  open_in;
   logic        en_ff,    en_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] climit_ff, climit_in;
   logic [31:0] tlimit_ff, tlimit_in;
   logic        tok_ff,   tok_in_nx;
   logic        evhit_ff, evhit_in;

   logic        sel;
   logic [31:0] base;
   logic [32:0] sum;
   logic [31:0] sat;
   logic        ev_met;
   logic [31:0] elapsed;
   logic        time_due;
   logic        count_due;
   logic        hit;
   logic [1:0]  cause;

   assign sel = (32'(cmd.entry) == CELL_ID);

   // event read-modify-write
   always_comb begin
      base   = open_ff ? count_ff : 32'd0;
      sum    = {1'b0, base} + {17'd0, cmd.count_add};
      sat    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      ev_met = (climit_ff != 32'd0) && (sat >= climit_ff);
   end

   // tick evaluation while the token sits here
   always_comb begin
      elapsed   = cmd.now_time - start_ff;
      time_due  = (tlimit_ff != 32'd0) && (elapsed >= tlimit_ff);
      count_due = (climit_ff != 32'd0) && (count_ff >= climit_ff);
      hit       = 1'b0;
      cause     = CAUSE_UNTHRESHOLDED;
      if (tok_ff && open_ff) begin
         if (!en_ff) begin
            hit   = 1'b1;
            cause = CAUSE_UNTHRESHOLDED;
         end else if (time_due) begin
            hit   = 1'b1;
            cause = CAUSE_TIME;
         end else if (count_due) begin
            hit   = 1'b1;
            cause = CAUSE_COUNT_TICK;
         end
      end
   end

   always_comb begin
      open_in   = open_ff;
      en_in     = en_ff;
      count_in  = count_ff;
      start_in  = start_ff;
      climit_in = climit_ff;
      tlimit_in = tlimit_ff;
      evhit_in  = evhit_ff;
      tok_in_nx = advance ? tok_in : tok_ff;
      if (cmd.prog && sel) begin
         climit_in = cmd.count_limit;
         tlimit_in = cmd.time_limit;
         en_in     = cmd.enabled;
      end
      if (cmd.evt) begin
         evhit_in = sel && ev_met;
         if (sel) begin
            count_in = sat;
            open_in  = !ev_met;
            if (!open_ff) begin
               start_in = cmd.now_time;
            end
         end
      end
      // close the window once its result moves on
      if (hit && advance) begin
         open_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         en_ff     <= 1'b0;
         count_ff  <= 32'd0;
         start_ff  <= 32'd0;
         climit_ff <= 32'd0;
         tlimit_ff <= 32'd0;
         tok_ff    <= 1'b0;
         evhit_ff  <= 1'b0;
      end else begin
         open_ff   <= open_in;
         en_ff     <= en_in;
         count_ff  <= count_in;
         start_ff  <= start_in;
         climit_ff <= climit_in;
         tlimit_ff <= tlimit_in;
         tok_ff    <= tok_in_nx;
         evhit_ff  <= evhit_in;
      end
   end

   assign tok_out     = tok_ff;
   assign stat.hit    = hit;
   assign stat.cause  = cause;
   assign stat.ev_hit = evhit_ff;

endmodule

>>> rtl/etw_ctrl.sv
// ----------------------------------------------------------------------------
// etw_ctrl
// Request sequencer, result ordering and response register.
// ----------------------------------------------------------------------------
module etw_ctrl #(
   parameter int ENTRIES = etw_pkg::ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic [3:0]             req_entry,
   input  logic [15:0]            req_count_add,
   input  logic [31:0]            req_now_time,
   input  logic [31:0]            req_set_count_limit,
   input  logic [31:0]            req_set_time_limit,
   input  logic                   req_set_enabled,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_fired_entry,
   output logic [1:0]             rsp_cause,
   output logic                   rsp_last,
   output etw_pkg::cmd_type       cmd,
   output logic                   advance,
   output logic                   inject,
   input  logic                   tok_last,
   input  etw_pkg::cell_stat_type stat [ENTRIES]
);
   import etw_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_EVRES = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type   state_ff, state_in;

   logic [1:0]  op_ff;
   logic [3:0]  entry_ff;
   logic [15:0] add_ff;
   logic [31:0] now_ff;
   logic [31:0] climit_ff;
   logic [31:0] tlimit_ff;
   logic        en_ff;

   logic        held_v_ff, held_v_in;
   logic [3:0]  held_e_ff, held_e_in;
   logic [1:0]  held_c_ff, held_c_in;

   logic        out_v_ff, out_v_in;
   logic [3:0]  out_e_ff, out_e_in;
   logic [1:0]  out_c_ff, out_c_in;
   logic        out_l_ff, out_l_in;

   logic        accept;
   logic        out_free;
   logic        hit_any;
   logic [3:0]  hit_idx;
   logic [1:0]  hit_cause;
   logic        ev_any;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !out_v_ff || !rsp_stall;

   // only one cell holds the token, so the flags are one-hot
   always_comb begin
      hit_any   = 1'b0;
      hit_idx   = 4'd0;
      hit_cause = 2'd0;
      ev_any    = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         ev_any = ev_any | stat[i].ev_hit;
         if (stat[i].hit) begin
            hit_any   = 1'b1;
            hit_idx   = hit_idx | 4'(i);
            hit_cause = hit_cause | stat[i].cause;
         end
      end
   end

   assign advance = (state_ff != ST_SCAN) || !(hit_any && held_v_ff && !out_free);
   assign inject  = (state_ff == ST_EXEC) && (op_ff == OP_TICK);

   always_comb begin
      cmd.prog        = (state_ff == ST_EXEC) && (op_ff == OP_PROGRAM);
      cmd.evt         = (state_ff == ST_EXEC) && (op_ff == OP_EVENT);
      cmd.entry       = entry_ff;
      cmd.count_add   = add_ff;
      cmd.now_time    = now_ff;
      cmd.count_limit = climit_ff;
      cmd.time_limit  = tlimit_ff;
      cmd.enabled     = en_ff;
   end

   always_comb begin
      state_in  = state_ff;
      held_v_in = held_v_ff;
      held_e_in = held_e_ff;
      held_c_in = held_c_ff;
      out_v_in  = out_v_ff && rsp_stall;
      out_e_in  = out_e_ff;
      out_c_in  = out_c_ff;
      out_l_in  = out_l_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_EVENT: state_in = ST_EVRES;
               OP_TICK:  state_in = ST_SCAN;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_EVRES: begin
            if (!ev_any) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_v_in = 1'b1;
               out_e_in = entry_ff;
               out_c_in = CAUSE_COUNT_EVENT;
               out_l_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (advance) begin
               if (hit_any) begin
                  // release the previous hit, keep the new one back
                  if (held_v_ff) begin
                     out_v_in = 1'b1;
                     out_e_in = held_e_ff;
                     out_c_in = held_c_ff;
                     out_l_in = 1'b0;
                  end
                  held_v_in = 1'b1;
                  held_e_in = hit_idx;
                  held_c_in = hit_cause;
               end
               if (tok_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!held_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_v_in  = 1'b1;
               out_e_in  = held_e_ff;
               out_c_in  = held_c_ff;
               out_l_in  = 1'b1;
               held_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         held_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         held_v_ff <= held_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      held_e_ff <= held_e_in;
      held_c_ff <= held_c_in;
      out_e_ff  <= out_e_in;
      out_c_ff  <= out_c_in;
      out_l_ff  <= out_l_in;
      if (accept) begin
         op_ff     <= req_opcode;
         entry_ff  <= req_entry;
         add_ff    <= req_count_add;
         now_ff    <= req_now_time;
         climit_ff <= req_set_count_limit;
         tlimit_ff <= req_set_time_limit;
         en_ff     <= req_set_enabled;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_fired_entry = out_e_ff;
   assign rsp_cause       = out_c_ff;
   assign rsp_last        = out_l_ff;

endmodule

>>> rtl/event_threshold_window_table_core.sv
// A program request busies the block through ST_EXEC only; an event request
//   shows its result when the block goes free, which rsp_stall can delay.
// A tick request walks the token through the cell chain, one cell a cycle
//   unless a held hit waits on rsp_stall, and then sends its last held hit.
// One request at a time; reset clears every entry.
// ----------------------------------------------------------------------------
// event_threshold_window_table_core
// Rule table of count/timeout coalescing windows built as a chain of cells.
// ----------------------------------------------------------------------------
module event_threshold_window_table_core #(
   parameter int ENTRIES = etw_pkg::ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_entry,
   input  logic [15:0] req_count_add,
   input  logic [31:0] req_now_time,
   input  logic [31:0] req_set_count_limit,
   input  logic [31:0] req_set_time_limit,
   input  logic        req_set_enabled,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_fired_entry,
   output logic [1:0]  rsp_cause,
   output logic        rsp_last
);
   import etw_pkg::*;

   cmd_type       cmd;
   logic          advance;
   logic          inject;
   logic          tok [ENTRIES+1];
   cell_stat_type stat [ENTRIES];

   assign tok[0] = inject;

   etw_ctrl #(
      .ENTRIES(ENTRIES)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_entry          (req_entry),
      .req_count_add      (req_count_add),
      .req_now_time       (req_now_time),
      .req_set_count_limit(req_set_count_limit),
      .req_set_time_limit (req_set_time_limit),
      .req_set_enabled    (req_set_enabled),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fired_entry    (rsp_fired_entry),
      .rsp_cause          (rsp_cause),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .advance            (advance),
      .inject             (inject),
      .tok_last           (tok[ENTRIES]),
      .stat               (stat)
   );

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      etw_cell #(
         .CELL_ID(g)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd),
         .advance(advance),
         .tok_in (tok[g]),
         .tok_out(tok[g+1]),
         .stat   (stat[g])
      );
   end

endmodule

>>> rtl/etw_checker.sv
// ----------------------------------------------------------------------------
// etw_checker
// Port-level checks for the event threshold window table core.
// ----------------------------------------------------------------------------
module etw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_fired_entry,
   input logic [1:0]  rsp_cause,
   input logic        rsp_last
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fired_entry)
         && $stable(rsp_cause) && $stable(rsp_last))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // a tick that is not done yet keeps the block busy
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("block went idle before the last response");

endmodule

bind event_threshold_window_table_core etw_checker u_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the event threshold window table. Requests are
// mirrored into a software copy of the rule table, which queues the windows
// that must close; every response is matched against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;
   import etw_pkg::*;

   localparam int          ENTRIES         = ENTRIES_DEF;
   localparam logic [1:0]  OP_UNUSED       = 2'd3;
   localparam int          RANDOM_ITEMS    = 200;
   localparam int          BIG_ADD_EVENTS  = 20;
   localparam logic [31:0] LARGE_LIMIT     = 32'(BIG_ADD_EVENTS) * 32'hFFFF;
   localparam int          RSP_HOLD_CYCLES = 400;
   localparam int          CYCLE_LIMIT     = 2_000_000;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  entry;
      logic [15:0] count_add;
      logic [31:0] now_time;
      logic [31:0] set_count_limit;
      logic [31:0] set_time_limit;
      logic        set_enabled;
   } rule_req_t;

   typedef struct packed {
      logic [3:0] entry;
      logic [1:0] cause;
      logic       last;
   } fire_rsp_t;

   logic        clock;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode          = OP_PROGRAM;
   logic [3:0]  req_entry           = '0;
   logic [15:0] req_count_add       = '0;
   logic [31:0] req_now_time        = '0;
   logic [31:0] req_set_count_limit = '0;
   logic [31:0] req_set_time_limit  = '0;
   logic        req_set_enabled     = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall           = 1'b0;
   logic [3:0]  rsp_fired_entry;
   logic [1:0]  rsp_cause;
   logic        rsp_last;

   // software copy of the rule table
   logic        win_open  [ENTRIES];
   logic [31:0] win_count [ENTRIES];
   logic [31:0] win_start [ENTRIES];
   logic [31:0] lim_count [ENTRIES];
   logic [31:0] lim_time  [ENTRIES];
   logic        rule_on   [ENTRIES];

   fire_rsp_t   pending_fires[$];
   int          fail_count       = 0;
   int          cycle_count      = 0;
   int          stall_left       = 0;
   bit          gaps_on          = 1'b0;
   bit          rsp_idle_on      = 1'b0;
   bit          hold_rsp_request = 1'b0;
   logic [31:0] clk_now;

   event_threshold_window_table_core #(
      .ENTRIES(ENTRIES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_entry(req_entry),
      .req_count_add(req_count_add),
      .req_now_time(req_now_time),
      .req_set_count_limit(req_set_count_limit),
      .req_set_time_limit(req_set_time_limit),
      .req_set_enabled(req_set_enabled),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_fired_entry(rsp_fired_entry),
      .rsp_cause(rsp_cause),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic rule_req_t make_program(input logic [3:0] e, input logic [31:0] cl,
                                              input logic [31:0] tl, input logic en);
      rule_req_t r;
      r.opcode          = OP_PROGRAM;
      r.entry           = e;
      r.count_add       = 16'($urandom);
      r.now_time        = $urandom;
      r.set_count_limit = cl;
      r.set_time_limit  = tl;
      r.set_enabled     = en;
      return r;
   endfunction

   function automatic rule_req_t make_event(input logic [3:0] e, input logic [15:0] add,
                                            input logic [31:0] now);
      rule_req_t r;
      r.opcode          = OP_EVENT;
      r.entry           = e;
      r.count_add       = add;
      r.now_time        = now;
      r.set_count_limit = $urandom;
      r.set_time_limit  = $urandom;
      r.set_enabled     = 1'($urandom);
      return r;
   endfunction

   function automatic rule_req_t make_tick(input logic [31:0] now, input logic [1:0] op);
      rule_req_t r;
      r.opcode          = op;
      r.entry           = 4'($urandom);
      r.count_add       = 16'($urandom);
      r.now_time        = now;
      r.set_count_limit = $urandom;
      r.set_time_limit  = $urandom;
      r.set_enabled     = 1'($urandom);
      return r;
   endfunction

   // update the table copy and queue the windows this request closes
   task automatic predict_fires(input rule_req_t r);
      fire_rsp_t   burst[$];
      fire_rsp_t   f;
      logic [32:0] sum;
      logic [31:0] elapsed;
      logic [1:0]  c;
      bit          due;
      case (r.opcode)
         OP_PROGRAM: begin
            lim_count[r.entry] = r.set_count_limit;
            lim_time[r.entry]  = r.set_time_limit;
            rule_on[r.entry]   = r.set_enabled;
         end
         OP_EVENT: begin
            if (!win_open[r.entry]) begin
               win_count[r.entry] = '0;
               win_start[r.entry] = r.now_time;
               win_open[r.entry]  = 1'b1;
            end
            sum = {1'b0, win_count[r.entry]} + {17'd0, r.count_add};
            win_count[r.entry] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (lim_count[r.entry] != 0 && win_count[r.entry] >= lim_count[r.entry]) begin
               win_open[r.entry] = 1'b0;
               f.entry = r.entry;
               f.cause = CAUSE_COUNT_EVENT;
               f.last  = 1'b1;
               pending_fires.push_back(f);
            end
         end
         OP_TICK: begin
            for (int i = 0; i < ENTRIES; i++) begin
               elapsed = r.now_time - win_start[i];
               due     = 1'b1;
               if (!rule_on[i])
                  c = CAUSE_UNTHRESHOLDED;
               else if (lim_time[i] != 0 && elapsed >= lim_time[i])
                  c = CAUSE_TIME;
               else if (lim_count[i] != 0 && win_count[i] >= lim_count[i])
                  c = CAUSE_COUNT_TICK;
               else
                  due = 1'b0;
               if (win_open[i] && due) begin
                  win_open[i] = 1'b0;
                  f.entry = i[3:0];
                  f.cause = c;
                  f.last  = 1'b0;
                  burst.push_back(f);
               end
            end
            if (burst.size() != 0)
               burst[burst.size() - 1].last = 1'b1;
            foreach (burst[k])
               pending_fires.push_back(burst[k]);
         end
         default: ;
      endcase
   endtask

   task automatic send_request(input rule_req_t r);
      req_valid           <= 1'b1;
      req_opcode          <= r.opcode;
      req_entry           <= r.entry;
      req_count_add       <= r.count_add;
      req_now_time        <= r.now_time;
      req_set_count_limit <= r.set_count_limit;
      req_set_time_limit  <= r.set_time_limit;
      req_set_enabled     <= r.set_enabled;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_fires(r);
      if (gaps_on && $urandom_range(0, 99) < 40) begin
         req_valid <= 1'b0;
         repeat (pick_idle_len()) @(posedge clock);
      end
   endtask

   // hold the sender until every queued result is out, then let a silent tick finish
   task automatic wait_all_fired();
      req_valid <= 1'b0;
      while (pending_fires.size() != 0) @(posedge clock);
      repeat (ENTRIES + 6) @(posedge clock);
   endtask

   task automatic test_directed();
      gaps_on     = 1'b1;
      rsp_idle_on = 1'b1;
      // count threshold of one: zero add keeps it open, next add closes it
      send_request(make_program(4'd0, 32'd1, 32'd0, 1'b1));
      send_request(make_event(4'd0, 16'd0, 32'd5));
      send_request(make_event(4'd0, 16'd1, 32'd6));
      send_request(make_program(4'd1, 32'd0, 32'd10, 1'b1));
      send_request(make_program(4'd2, 32'd5, 32'd0, 1'b0));
      send_request(make_program(4'd3, 32'd10, 32'd0, 1'b1));
      send_request(make_program(4'd4, 32'd2, 32'd1, 1'b1));
      send_request(make_event(4'd1, 16'd3, 32'hFFFF_FFFA));
      send_request(make_event(4'd2, 16'd1, 32'd0));
      send_request(make_event(4'd3, 16'd4, 32'd0));
      send_request(make_event(4'd4, 16'd1, 32'd100));
      // lower limits to or below the open counts; time beats count on entry 4
      send_request(make_program(4'd3, 32'd3, 32'd0, 1'b1));
      send_request(make_program(4'd4, 32'd1, 32'd1, 1'b1));
      // entry 1 is one time unit short across the time wrap
      send_request(make_tick(32'd3, OP_TICK));
      send_request(make_tick(32'd4, OP_TICK));
      send_request(make_tick(32'd5, OP_TICK));
      send_request(make_tick($urandom, OP_UNUSED));
      // count closes at the event even with thresholding off
      send_request(make_event(4'd2, 16'd5, 32'd7));
      send_request(make_program(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      send_request(make_event(4'd15, 16'hFFFF, 32'hFFFF_FFFF));
      send_request(make_tick(32'hFFFF_FFFE, OP_TICK));
   endtask

   // wide counts: a limit one above the count holds, an exact one closes
   task automatic test_large_counts();
      gaps_on     = 1'b0;
      rsp_idle_on = 1'b0;
      send_request(make_program(4'd7, 32'd0, 32'd0, 1'b1));
      for (int n = 0; n < BIG_ADD_EVENTS; n++)
         send_request(make_event(4'd7, 16'hFFFF, 32'd0));
      send_request(make_program(4'd7, LARGE_LIMIT + 32'd1, 32'd0, 1'b1));
      send_request(make_event(4'd7, 16'd0, 32'd0));
      send_request(make_program(4'd7, LARGE_LIMIT, 32'd0, 1'b1));
      send_request(make_event(4'd7, 16'd0, 32'd0));
   endtask

   task automatic test_random_traffic();
      rule_req_t   r;
      int          pick;
      logic [31:0] cl;
      logic [31:0] tl;
      logic [15:0] add;
      clk_now = 32'hFFFF_FF00;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gaps_on     = (n % 100) >= 25;
         rsp_idle_on = gaps_on;
         if ($urandom_range(0, 49) == 0)
            clk_now = $urandom;
         else
            clk_now = clk_now + $urandom_range(0, 4);
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            pick = $urandom_range(0, 99);
            cl = (pick < 20) ? 32'd0 : (pick < 80) ? $urandom_range(1, 16) : $urandom;
            pick = $urandom_range(0, 99);
            tl = (pick < 25) ? 32'd0 : (pick < 85) ? $urandom_range(1, 20) : $urandom;
            r = make_program(4'($urandom), cl, tl, $urandom_range(0, 99) < 80);
         end else if (pick < 70) begin
            add = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 6)) : 16'($urandom);
            r = make_event(4'($urandom), add, clk_now);
         end else if (pick < 95) begin
            r = make_tick(clk_now, OP_TICK);
         end else begin
            r = make_tick(clk_now, OP_UNUSED);
         end
         send_request(r);
      end
   endtask

   // receiver holds off while every window is opened and swept repeatedly
   task automatic test_backpressure();
      gaps_on     = 1'b0;
      rsp_idle_on = 1'b0;
      for (int e = 0; e < ENTRIES; e++)
         send_request(make_program(e[3:0], 32'd0, $urandom, 1'b0));
      hold_rsp_request = 1'b1;
      for (int round = 0; round < 3; round++) begin
         for (int e = 0; e < ENTRIES; e++)
            send_request(make_event(e[3:0], 16'($urandom), $urandom));
         send_request(make_tick($urandom, OP_TICK));
      end
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         win_open[i]  = 1'b0;
         win_count[i] = '0;
         win_start[i] = '0;
         lim_count[i] = '0;
         lim_time[i]  = '0;
         rule_on[i]   = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_all_fired();
      test_large_counts();
      test_random_traffic();
      wait_all_fired();
      test_backpressure();
      wait_all_fired();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_rsp_request) begin
         hold_rsp_request = 1'b0;
         stall_left       = RSP_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 99) < 25) begin
         rsp_stall <= 1'b1;
         stall_left = pick_idle_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      fire_rsp_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_fires.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, actual entry %0d cause %0d last %0d",
                     $time, rsp_fired_entry, rsp_cause, rsp_last);
         end else begin
            want = pending_fires.pop_front();
            if (rsp_fired_entry !== want.entry) begin
               fail_count++;
               $display("%0t: fired_entry expected %0d actual %0d",
                        $time, want.entry, rsp_fired_entry);
            end
            if (rsp_cause !== want.cause) begin
               fail_count++;
               $display("%0t: cause expected %0d actual %0d", $time, want.cause, rsp_cause);
            end
            if (rsp_last !== want.last) begin
               fail_count++;
               $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_fires.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule

>>> event_threshold_window_table_core.f
rtl/etw_pkg.sv
rtl/etw_cell.sv
rtl/etw_ctrl.sv
rtl/event_threshold_window_table_core.sv
rtl/etw_checker.sv
test/tb_top.sv
